/* rtl/s256_pkg.sv */
// shared types, codes and constants of the streaming sha-256 hasher
// no dependencies; compiled before every other file of the block
package s256_pkg;

   typedef logic [31:0]       word_type;
   typedef logic [7:0][31:0]  hash_type;     // index 0 is a / h0
   typedef logic [15:0][31:0] window_type;   // index 0 is the oldest schedule word

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] BLOCK_LAST = 6'd63;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;
   localparam logic [1:0] LANE_LAST  = 2'd3;

   // initial hash value, h7 down to h0
   localparam hash_type SHA_IV = {
      32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
      32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

/* rtl/s256_if.sv */
// valid/ready channel interfaces of the sha-256 hasher: request and response
// no dependencies
interface s256_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface s256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

/* rtl/s256_round.sv */
// shared sha-256 round unit: one compression round plus one schedule word
// depends on s256_pkg
module s256_round
   import s256_pkg::*;
(
   input  hash_type   vars_i,
   input  window_type win_i,
   input  word_type   k_i,
   output hash_type   vars_o,
   output word_type   w_next_o
);

   word_type a, b, c, d, e, f, g, h;
   word_type w0, w1, w9, w14;
   word_type big_s0, big_s1, ch, maj, sml_s0, sml_s1, t1, t2;

   always_comb begin
      {h, g, f, e, d, c, b, a} = vars_i;
      w0  = win_i[0];
      w1  = win_i[1];
      w9  = win_i[9];
      w14 = win_i[14];

      big_s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
      big_s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
      ch     = (e & f) ^ (~e & g);
      maj    = (a & b) ^ (a & c) ^ (b & c);
      t1     = h + big_s1 + ch + k_i + w0;
      t2     = big_s0 + maj;

      sml_s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
      sml_s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
      w_next_o = w0 + sml_s0 + w9 + sml_s1;

      vars_o = {g, f, e, d + t1, c, b, a, t1 + t2};
   end

endmodule

/* rtl/sha256_stream_hasher.sv */
// streaming sha-256 hasher. a request word carries either one message byte
// (absorb) or the finish command. every 64th absorbed byte starts the
// compression, which runs one round a cycle through a single shared round
// unit and then folds the working variables into the chain value. a finish
// pushes the pad byte, the zero bytes and the eight length bytes through the
// same byte path one a cycle, held while a compression runs (one or two
// compressions in all), then hands out the eight digest words, h0 first, one
// per accepted response word, with last_word on the eighth. after that the
// chain value and the byte count go back to their initial values. req ready
// is high only while the block is idle; the loop through the round unit sets
// the block rate
// depends on s256_pkg, s256_if and s256_round
module sha256_stream_hasher
   import s256_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   s256_req_if.sink          req_bus,
   s256_rsp_if.source        rsp_bus
);

   // control state
   state_type   state_ff, state_in;
   logic [60:0] len_ff, len_in;        // bytes absorbed, wraps
   hash_type    chain_ff, chain_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        padding_ff, padding_in; // finish sequence under way
   logic        first_ff, first_in;     // next pad byte is the 0x80 marker
   logic        lenph_ff, lenph_in;     // length bytes being appended
   logic [2:0]  emit_ff, emit_in;

   // payload
   hash_type    vars_ff, vars_in;
   window_type  win_ff, win_in;
   logic [23:0] cur_ff, cur_in;       // partial big-endian word
   logic [63:0] bits_ff, bits_in;     // message length in bits, latched at finish

   // byte path
   logic        absorb_en;
   logic [7:0]  absorb_byte;
   logic [5:0]  pos;
   logic [5:0]  pos_next;

   // round unit
   hash_type    round_vars;
   word_type    round_w;

   s256_round u_round (
      .vars_i   (vars_ff),
      .win_i    (win_ff),
      .k_i      (ROUND_K[rnd_ff]),
      .vars_o   (round_vars),
      .w_next_o (round_w)
   );

   assign pos      = len_ff[5:0];
   assign pos_next = pos + 6'd1;

   // response is read straight out of the chain registers
   assign rsp_bus.valid       = (state_ff == ST_EMIT);
   assign rsp_bus.digest_word = chain_ff[emit_ff];
   assign rsp_bus.word_index  = emit_ff;
   assign rsp_bus.last_word   = (emit_ff == WORD_LAST);

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      chain_in    = chain_ff;
      rnd_in      = rnd_ff;
      padding_in  = padding_ff;
      first_in    = first_ff;
      lenph_in    = lenph_ff;
      emit_in     = emit_ff;
      vars_in     = vars_ff;
      win_in      = win_ff;
      cur_in      = cur_ff;
      bits_in     = bits_ff;
      absorb_en   = 1'b0;
      absorb_byte = 8'h00;
      req_bus.ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               if (req_bus.cmd == CMD_FINISH) begin
                  bits_in    = {len_ff, 3'b000};
                  padding_in = 1'b1;
                  first_in   = 1'b1;
                  lenph_in   = 1'b0;
                  state_in   = ST_PAD;
               end else begin
                  absorb_en   = 1'b1;
                  absorb_byte = req_bus.data_byte;
               end
            end
         end
         ST_PAD: begin
            absorb_en = 1'b1;
            first_in  = 1'b0;
            if (first_ff) begin
               absorb_byte = PAD_BYTE;
            end else if (lenph_ff) begin
               // big-endian length, top byte at position 56
               absorb_byte = bits_ff[{~pos[2:0], 3'b000} +: 8];
            end
            if (!lenph_ff && pos_next == LEN_POS) begin
               lenph_in = 1'b1;
            end
         end
         ST_ROUND: begin
            vars_in = round_vars;
            win_in  = {round_w, win_ff[15:1]};
            rnd_in  = rnd_ff + 6'd1;
            if (rnd_ff == ROUND_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
            emit_in = 3'd0;
            if (!padding_ff) begin
               state_in = ST_IDLE;
            end else if (lenph_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (rsp_bus.ready) begin
               emit_in = emit_ff + 3'd1;
               if (emit_ff == WORD_LAST) begin
                  chain_in   = SHA_IV;
                  len_in     = '0;
                  padding_in = 1'b0;
                  lenph_in   = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // shared byte path: gather bytes into words, words into the window
      if (absorb_en) begin
         cur_in = {cur_ff[15:0], absorb_byte};
         len_in = len_ff + 61'd1;
         if (pos[1:0] == LANE_LAST) begin
            win_in = {cur_ff, absorb_byte, win_ff[15:1]};
         end
         if (pos == BLOCK_LAST) begin
            vars_in  = chain_ff;
            rnd_in   = 6'd0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         len_ff     <= '0;
         chain_ff   <= SHA_IV;
         rnd_ff     <= '0;
         padding_ff <= 1'b0;
         first_ff   <= 1'b0;
         lenph_ff   <= 1'b0;
         emit_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         chain_ff   <= chain_in;
         rnd_ff     <= rnd_in;
         padding_ff <= padding_in;
         first_ff   <= first_in;
         lenph_ff   <= lenph_in;
         emit_ff    <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
      win_ff  <= win_in;
      cur_ff  <= cur_in;
      bits_ff <= bits_in;
   end

endmodule

/* rtl/sha256_stream_hasher_checker.sv */
// port-level checks of the sha-256 hasher, bound to the top level
// depends on s256_pkg and sha256_stream_hasher
module sha256_stream_hasher_checker
   import s256_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_cmd,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // requests are never taken while digest words are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a digest word is offered");

   // a finish closes the request side at once
   a_finish_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == CMD_FINISH) |=> !req_ready)
      else $error("request ready right after a finish");

   // digest words follow one another with rising index
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
      (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word sequence broken");

   // last flag sits on the eighth word only
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == WORD_LAST)))
      else $error("last_word does not match word_index");

   // a stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_word)))
      else $error("digest word changed while stalled");

endmodule

bind sha256_stream_hasher sha256_stream_hasher_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_cmd         (req_bus.cmd),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_digest_word (rsp_bus.digest_word),
   .rsp_word_index  (rsp_bus.word_index),
   .rsp_last_word   (rsp_bus.last_word)
);

/* sim/s256_digest_book.sv */
// digest bookkeeping for the sha-256 hasher bench: a software hash of the
// accepted request words and the queue of digest words still to arrive
// depends on s256_pkg for the hash types, the initial value and the round constants
package s256_digest_book_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import s256_pkg::*;

   typedef struct {
      word_type   digest;
      logic [2:0] slot;
      logic       last;
   } digest_entry_type;

   class digest_book;
      hash_type         chain;
      logic [7:0]       block_buf [64];
      logic [60:0]      byte_count;
      digest_entry_type awaited [$];
      int               errors;
      int               words_checked;

      function new();
         chain         = SHA_IV;
         byte_count    = '0;
         errors        = 0;
         words_checked = 0;
         foreach (block_buf[i]) block_buf[i] = 8'h00;
      endfunction

      local function word_type rotr(word_type v, int unsigned s);
         return (v >> s) | (v << (32 - s));
      endfunction

      // one byte into the block buffer, compressing once the block is full
      local function void absorb_byte(logic [7:0] value);
         word_type    sched [64];
         word_type    wv [8];
         word_type    t1;
         word_type    t2;
         logic [5:0]  pos;
         pos = byte_count[5:0];
         block_buf[pos] = value;
         byte_count = byte_count + 61'd1;
         if (pos == BLOCK_LAST) begin
            for (int t = 0; t < 16; t++)
               sched[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2],
                           block_buf[4*t+3]};
            for (int t = 16; t < 64; t++)
               sched[t] = (rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10))
                        + sched[t-7]
                        + (rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3))
                        + sched[t-16];
            for (int j = 0; j < 8; j++) wv[j] = chain[j];
            for (int t = 0; t < 64; t++) begin
               t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
                  + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + ROUND_K[t] + sched[t];
               t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
                  + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
               for (int j = 7; j > 0; j--) wv[j] = wv[j-1];
               wv[4] = wv[4] + t1;
               wv[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++) chain[j] = chain[j] + wv[j];
         end
      endfunction

      // an accepted request word; a finish pads, queues the digest and restarts
      function void note_word(logic op, logic [7:0] value);
         logic [63:0] bit_len;
         digest_entry_type entry;
         if (op == CMD_ABSORB) begin
            absorb_byte(value);
         end else begin
            bit_len = {byte_count, 3'b000};
            absorb_byte(PAD_BYTE);
            while (byte_count[5:0] != LEN_POS) absorb_byte(8'h00);
            for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
               entry.digest = chain[i];
               entry.slot   = i[2:0];
               entry.last   = (i[2:0] == WORD_LAST);
               awaited.push_back(entry);
            end
            chain      = SHA_IV;
            byte_count = '0;
         end
      endfunction

      function void check_word(word_type digest, logic [2:0] slot, logic last);
         digest_entry_type entry;
         if (awaited.size() == 0) begin
            $display("%0t ns: digest word %h (index %0d) with none outstanding",
                     $time, digest, slot);
            errors++;
            return;
         end
         entry = awaited.pop_front();
         words_checked++;
         if (digest !== entry.digest) begin
            $display("%0t ns: digest_word expected %h, got %h", $time, entry.digest, digest);
            errors++;
         end
         if (slot !== entry.slot) begin
            $display("%0t ns: word_index expected %0d, got %0d", $time, entry.slot, slot);
            errors++;
         end
         if (last !== entry.last) begin
            $display("%0t ns: last_word expected %b, got %b", $time, entry.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

endpackage

/* sim/sha256_stream_hasher_tb.sv */
// self-checking bench of the streaming sha-256 hasher: directed and random
// messages, digests predicted in software and compared word by word
// depends on s256_pkg, s256_if, the hasher rtl and s256_digest_book_pkg
module sha256_stream_hasher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import s256_pkg::*;
   import s256_digest_book_pkg::*;

   logic clock = 1'b0;
   logic reset;

   s256_req_if req_bus ();
   s256_rsp_if rsp_bus ();

   sha256_stream_hasher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   digest_book book;

   // shared between the sender and the receiver
   logic calm;             // no idling on either side for the current message
   logic hold_off_req;     // asks the receiver for one long hold-off
   int   sent_words;
   int   messages;
   int   longest;
   int   hold_offs;

   always #5ns clock = ~clock;

   // one request word: random gap, then hold it until the block takes it
   task automatic offer_word(input logic op, input logic [7:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= op;
      req_bus.data_byte <= value;
      do @(posedge clock); while (!req_bus.ready);
      book.note_word(op, value);
      sent_words++;
   endtask

   // a message of random bytes closed by a finish with a random stray byte
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) offer_word(CMD_ABSORB, 8'($urandom_range(0, 255)));
      offer_word(CMD_FINISH, 8'($urandom_range(0, 255)));
      messages++;
      if (len > longest) longest = len;
   endtask

   // receiver: random stall before each digest word, plus one long hold-off
   // while the sender keeps offering, so the block backs up into its input
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            stall        = 300;
            hold_off_req = 1'b0;
            hold_offs++;
         end else begin
            stall = calm ? 0 : $urandom_range(0, 17);
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         book.check_word(rsp_bus.digest_word, rsp_bus.word_index, rsp_bus.last_word);
      end
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   initial begin
      int boundary_lengths [9];
      int len;
      boundary_lengths  = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
      book              = new();
      calm              = 1'b0;
      hold_off_req      = 1'b0;
      sent_words        = 0;
      messages          = 0;
      longest           = 0;
      hold_offs         = 0;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_ABSORB;
      req_bus.data_byte = 8'h00;
      reset             = 1'b1;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // directed: empty message, with every bit of the ignored byte set
      offer_word(CMD_FINISH, 8'hFF);
      messages++;
      // "abc"
      offer_word(CMD_ABSORB, 8'h61);
      offer_word(CMD_ABSORB, 8'h62);
      offer_word(CMD_ABSORB, 8'h63);
      offer_word(CMD_FINISH, 8'h00);
      messages++;
      // byte extremes
      offer_word(CMD_ABSORB, 8'h00);
      offer_word(CMD_ABSORB, 8'hFF);
      offer_word(CMD_FINISH, 8'h5A);
      messages++;
      // a data byte that looks like the pad byte
      offer_word(CMD_ABSORB, PAD_BYTE);
      offer_word(CMD_FINISH, PAD_BYTE);
      messages++;
      longest = 3;

      // random: mostly short messages, some around the padding and block
      // boundaries where the length spills into an extra block
      while (sent_words < 230) begin
         calm = ($urandom_range(0, 3) == 0);
         if (messages == 6) hold_off_req = 1'b1;
         if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 12);
         else len = boundary_lengths[$urandom_range(0, 8)];
         // keep the last message inside the word budget
         if (len > 229 - sent_words) len = 229 - sent_words;
         send_message(len);
      end
      calm = 1'b0;

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // drain, then give any stray digest word time to show up
      while (book.outstanding() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      $display("covered %0d messages in %0d request words, longest %0d bytes",
               messages, sent_words, longest);
      $display("checked %0d digest words, %0d long response hold-off(s)",
               book.words_checked, hold_offs);
      if (book.errors == 0 && book.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/s256_pkg.sv
rtl/s256_if.sv
rtl/s256_round.sv
rtl/sha256_stream_hasher.sv
rtl/sha256_stream_hasher_checker.sv
sim/s256_digest_book.sv
sim/sha256_stream_hasher_tb.sv
